>>> rtl/stpid_pkg.sv
// Shared types and constants for the stepper position PID loop.
package stpid_pkg;

	// Loop constants, hundredths of a degree and PID scale
	localparam int ITERM_MAX = 18000;
	localparam int HALF_TURN = 18000;
	localparam int TURN      = 36000;

	// Divider geometry
	localparam int unsigned DIVIDEND_W = 52;
	localparam int unsigned DIVISOR_W  = 20;
	localparam int unsigned QUOT_W     = 34;
	localparam int unsigned SHIFT_W    = 6;

	localparam logic [DIVISOR_W-1:0] PID_SCALE  = 20'd10000;
	localparam logic [SHIFT_W-1:0]   PID_QBITS  = 6'd13;
	localparam logic [SHIFT_W-1:0]   FILT_QBITS = 6'd33;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TUNING_MODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_ADVANCE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE    = 3'd7;

	typedef struct packed {
		logic                  start;
		logic [SHIFT_W-1:0]    qbits;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/stpid_div.sv
// Iterative restoring divider, one quotient bit per cycle, top bit flags overflow.
module stpid_div
	import stpid_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned DSH_W = DIVISOR_W + QUOT_W - 1;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DSH_W-1:0]      dsh_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [SHIFT_W-1:0]    cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DSH_W:0]        diff;
	logic                  ge;

	assign diff = {2'b00, rem_q} - {1'b0, dsh_q};
	assign ge   = ~diff[DSH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= ~req.start & busy_q & (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.qbits;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dsh_q  <= DSH_W'(req.divisor) << req.qbits;
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[DIVIDEND_W-1:0];
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> rtl/stepper_position_pid_loop.sv
// Stepper position PID loop: unwrap, PID or target tracking, drive limit, phase.
//
// One request on the input channel (in_valid/in_ready) carries a shaft angle and
// a step target; it yields exactly one result on the output channel
// (out_valid/out_ready): phase angle, effort, tracked target and position error.
// A single 32x16 multiplier and a one-bit-per-cycle divider are shared under a
// sequencer, so the block takes one request at a time and not a new one before
// it is through with the last. Tuning mode skips the divider; the divider works
// 14 quotient bits with the loop closed and 34 while tracking with the loop open.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; if the receiver stalls, the next
// request may still be taken and worked, and the sequencer holds its result
// until the output register frees.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (arst_n low) clears the loop state and restores register defaults.
module stepper_position_pid_loop
	import stpid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          angle_sample,
	input  logic signed [31:0]   target_steps,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [17:0]   phase_angle,
	output logic [11:0]          effort,
	output logic signed [31:0]   tracked_steps,
	output logic signed [31:0]   position_error
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_TARGET,
		ST_ERR,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_FILT_SCALE,
		ST_FILT_SUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_LIMIT,
		ST_OUT
	} state_t;

	localparam logic signed [32:0] ITERM_HI = 33'(ITERM_MAX);
	localparam logic signed [32:0] ITERM_LO = -ITERM_HI;
	localparam logic signed [17:0] HALF_HI  = 18'(HALF_TURN);
	localparam logic signed [17:0] HALF_LO  = -HALF_HI;
	localparam logic signed [17:0] TURN_18  = 18'(TURN);

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if ((v[39:31] == '0) || (v[39:31] == '1)) begin
			r = v[31:0];
		end else if (v[39]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	state_t state_q;

	// Configuration
	logic        loop_enable_q;
	logic        tuning_mode_q;
	logic [15:0] prop_gain_q;
	logic [15:0] integral_gain_q;
	logic [15:0] deriv_gain_q;
	logic [11:0] drive_limit_q;
	logic [15:0] phase_advance_q;
	logic [15:0] step_angle_q;

	// Loop state
	logic [31:0]        position_q;
	logic [31:0]        prev_position_q;
	logic [15:0]        prev_angle_q;
	logic signed [15:0] integrator_q;
	logic signed [12:0] drive_q;
	logic               out_valid_q;

	// Working registers
	logic [15:0]           angle_q;
	logic signed [31:0]    target_q;
	logic signed [31:0]    r_q;
	logic signed [31:0]    dy_q;
	logic signed [31:0]    err_q;
	logic signed [47:0]    prod_q;
	logic signed [51:0]    acc_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [SHIFT_W-1:0]    qbits_q;
	logic                  neg_q;
	logic signed [12:0]    u_q;
	logic signed [31:0]    tracked_q;

	// Output payload
	logic signed [17:0] phase_q;
	logic [11:0]        effort_q;
	logic signed [31:0] tracked_out_q;
	logic signed [31:0] err_out_q;

	logic     filt_mode;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign filt_mode = ~tuning_mode_q & ~loop_enable_q;
	assign in_ready  = (state_q == ST_IDLE);

	// Shared multiplier
	logic signed [31:0] mul_a;
	logic [15:0]        mul_b;
	logic signed [47:0] mul_full;
	logic               mul_en;

	always_comb begin
		mul_a  = target_q;
		mul_b  = step_angle_q;
		mul_en = 1'b0;
		unique case (state_q)
			ST_UNWRAP: begin
				mul_a  = target_q;
				mul_b  = step_angle_q;
				mul_en = 1'b1;
			end
			ST_ERR: begin
				// tracking filters a zero step angle as a step of one
				mul_a  = target_q;
				mul_b  = (step_angle_q == '0) ? 16'd1 : step_angle_q;
				mul_en = 1'b1;
			end
			ST_INTEG: begin
				mul_a  = err_q;
				mul_b  = prop_gain_q;
				mul_en = 1'b1;
			end
			ST_MUL_P: begin
				mul_a  = 32'(integrator_q);
				mul_b  = integral_gain_q;
				mul_en = 1'b1;
			end
			ST_MUL_I: begin
				mul_a  = dy_q;
				mul_b  = deriv_gain_q;
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_full = mul_a * $signed({1'b0, mul_b});

	// Angle unwrap
	logic signed [17:0] d_raw;
	logic signed [17:0] d_adj;
	logic [31:0]        pos_new;

	always_comb begin
		d_raw = $signed({2'b00, angle_q}) - $signed({2'b00, prev_angle_q});
		if (d_raw < HALF_LO) begin
			d_adj = d_raw + TURN_18;
		end else if (d_raw > HALF_HI) begin
			d_adj = d_raw - TURN_18;
		end else begin
			d_adj = d_raw;
		end
		pos_new = position_q + 32'(d_adj);
	end

	// Error and integrator
	logic signed [39:0] r_full;
	logic signed [32:0] err_diff;
	logic signed [32:0] it_sum;
	logic signed [15:0] it_clamped;

	always_comb begin
		r_full   = 40'(prod_q >>> 8);
		err_diff = 33'(r_q) - 33'($signed(position_q));
		it_sum   = 33'(integrator_q) + 33'(err_q);
		if (it_sum > ITERM_HI) begin
			it_clamped = 16'(ITERM_HI);
		end else if (it_sum < ITERM_LO) begin
			it_clamped = 16'(ITERM_LO);
		end else begin
			it_clamped = it_sum[15:0];
		end
	end

	// Filter scaling
	logic [15:0]          s_eff;
	logic [DIVISOR_W-1:0] s_times10;
	logic signed [51:0]   prod_ext;
	logic [DIVIDEND_W-1:0] acc_abs;

	always_comb begin
		s_eff     = (step_angle_q == '0) ? 16'd1 : step_angle_q;
		s_times10 = (DIVISOR_W'(s_eff) << 3) + (DIVISOR_W'(s_eff) << 1);
		prod_ext  = 52'(prod_q);
		acc_abs   = acc_q[51] ? DIVIDEND_W'(-acc_q) : DIVIDEND_W'(acc_q);
	end

	assign div_req.start    = (state_q == ST_DIV_START);
	assign div_req.qbits    = qbits_q;
	assign div_req.dividend = acc_abs;
	assign div_req.divisor  = divisor_q;

	stpid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Quotient to drive and tracked target
	logic [12:0]        q_pid;
	logic signed [13:0] u_pre;
	logic signed [13:0] lim14;
	logic signed [13:0] u_lim;
	logic [32:0]        q_filt;
	logic signed [31:0] tracked_new;

	always_comb begin
		q_pid  = div_rsp.quot[PID_QBITS] ? '1 : div_rsp.quot[12:0];
		q_filt = div_rsp.quot[32:0];
		lim14  = $signed({2'b00, drive_limit_q});
		if (tuning_mode_q) begin
			u_pre = 14'(drive_q);
		end else if (loop_enable_q) begin
			u_pre = neg_q ? -$signed({1'b0, q_pid}) : $signed({1'b0, q_pid});
		end else begin
			u_pre = '0;
		end
		if (u_pre > lim14) begin
			u_lim = lim14;
		end else if (u_pre < -lim14) begin
			u_lim = -lim14;
		end else begin
			u_lim = u_pre;
		end
		if (neg_q) begin
			if (div_rsp.quot[FILT_QBITS] || q_filt[32] || q_filt[31]) begin
				tracked_new = 32'sh8000_0000;
			end else begin
				tracked_new = -$signed(q_filt[31:0]);
			end
		end else begin
			if (div_rsp.quot[FILT_QBITS] || q_filt[32] || q_filt[31]) begin
				tracked_new = 32'sh7FFF_FFFF;
			end else begin
				tracked_new = $signed(q_filt[31:0]);
			end
		end
	end

	// Phase and effort
	logic signed [17:0] neg_angle;
	logic signed [17:0] phase_new;
	logic [11:0]        effort_new;
	logic               out_free;

	always_comb begin
		neg_angle = -$signed({2'b00, angle_q});
		if (u_q > 13'sd0) begin
			phase_new = neg_angle - $signed({2'b00, phase_advance_q});
		end else begin
			phase_new = neg_angle + $signed({2'b00, phase_advance_q});
		end
		effort_new = u_q[12] ? 12'(-u_q) : u_q[11:0];
		out_free   = ~out_valid_q | out_ready;
	end

	// Sequencer, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			loop_enable_q   <= 1'b0;
			tuning_mode_q   <= 1'b0;
			prop_gain_q     <= '0;
			integral_gain_q <= '0;
			deriv_gain_q    <= '0;
			drive_limit_q   <= '0;
			phase_advance_q <= 16'd9000;
			step_angle_q    <= 16'd2880;
			position_q      <= '0;
			prev_position_q <= '0;
			prev_angle_q    <= '0;
			integrator_q    <= '0;
			drive_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_LOOP_ENABLE:   loop_enable_q   <= cfg_data[0];
					REG_TUNING_MODE:   tuning_mode_q   <= cfg_data[0];
					REG_PROP_GAIN:     prop_gain_q     <= cfg_data;
					REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data;
					REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data;
					REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_data[11:0];
					REG_PHASE_ADVANCE: phase_advance_q <= cfg_data;
					REG_STEP_ANGLE:    step_angle_q    <= cfg_data;
					default:           ;
				endcase
			end

			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UNWRAP;
					end
				end
				ST_UNWRAP: begin
					position_q <= pos_new;
					state_q    <= ST_TARGET;
				end
				ST_TARGET: begin
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					if (tuning_mode_q) begin
						state_q <= ST_LIMIT;
					end else if (loop_enable_q) begin
						state_q <= ST_INTEG;
					end else begin
						state_q <= ST_FILT_SCALE;
					end
				end
				ST_INTEG: begin
					integrator_q <= it_clamped;
					state_q      <= ST_MUL_P;
				end
				ST_MUL_P:      state_q <= ST_MUL_I;
				ST_MUL_I:      state_q <= ST_MUL_D;
				ST_MUL_D:      state_q <= ST_DIV_START;
				ST_FILT_SCALE: begin
					integrator_q <= '0;
					state_q      <= ST_FILT_SUM;
				end
				ST_FILT_SUM:   state_q <= ST_DIV_START;
				ST_DIV_START:  state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_LIMIT;
					end
				end
				ST_LIMIT: begin
					drive_q         <= u_lim[12:0];
					prev_position_q <= position_q;
					prev_angle_q    <= angle_q;
					state_q         <= ST_OUT;
				end
				ST_OUT: begin
					// hold the result until the output register frees
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_full;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					angle_q   <= angle_sample;
					target_q  <= target_steps;
					tracked_q <= target_steps;
				end
			end
			ST_TARGET: begin
				r_q  <= sat32(r_full);
				dy_q <= $signed(position_q - prev_position_q);
			end
			ST_ERR: begin
				err_q     <= sat32(40'(err_diff));
				divisor_q <= PID_SCALE;
				qbits_q   <= PID_QBITS;
			end
			ST_MUL_P: acc_q <= prod_ext;
			ST_MUL_I: acc_q <= acc_q + prod_ext;
			ST_MUL_D: acc_q <= acc_q - prod_ext;
			ST_FILT_SCALE: begin
				acc_q     <= (prod_ext <<< 3) + prod_ext;
				divisor_q <= s_times10;
				qbits_q   <= FILT_QBITS;
			end
			ST_FILT_SUM: begin
				acc_q <= acc_q + (52'($signed(position_q)) <<< 8);
			end
			ST_DIV_START: neg_q <= acc_q[51];
			ST_LIMIT: begin
				u_q <= u_lim[12:0];
				if (filt_mode) begin
					tracked_q <= tracked_new;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					phase_q       <= phase_new;
					effort_q      <= effort_new;
					tracked_out_q <= tracked_q;
					err_out_q     <= filt_mode ? 32'sd0 : err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign phase_angle    = phase_q;
	assign effort         = effort_q;
	assign tracked_steps  = tracked_out_q;
	assign position_error = err_out_q;

endmodule
